FILE: src/ecc_pkg.sv
// ecc_pkg: shared types and constants for the edge connected components block
// used by ecc_cell, edge_connected_components and ecc_checker
package ecc_pkg;

    localparam int ECC_MAX_EDGES   = 32;
    localparam int ECC_VERTEX_BITS = 16;
    localparam int ECC_IN_VID_W    = 16;
    localparam int ECC_NUM_W       = 5;
    localparam int ECC_LABEL_W     = 5;
    localparam int ECC_TOTAL_W     = 6;

    // input word: one edge
    typedef struct packed {
        logic [ECC_IN_VID_W-1:0] start_vertex;
        logic [ECC_IN_VID_W-1:0] end_vertex;
        logic                    is_closed;
        logic                    last_edge;
    } ecc_in_t;

    // output word: one labeled edge
    typedef struct packed {
        logic [ECC_NUM_W-1:0]   edge_number;
        logic [ECC_LABEL_W-1:0] component_label;
        logic [ECC_TOTAL_W-1:0] component_total;
        logic                   overflow_flag;
        logic                   final_result;
    } ecc_out_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                   clear_en;
        logic                   closed_en;
        logic                   seed_en;
        logic                   grow_en;
        logic [ECC_LABEL_W-1:0] label;
    } ecc_cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLOSED,
        ST_SEED,
        ST_GROW,
        ST_EMIT
    } ecc_state_t;

endpackage

FILE: src/ecc_cell.sv
// ecc_cell: one edge slot of the labeling row
// holds the edge, its label and search marks; chains pick and broadcast to its neighbor
// depends on ecc_pkg
module ecc_cell
    import ecc_pkg::*;
#(
    parameter int VID_W = ECC_VERTEX_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ecc_cmd_t               cmd,
    input  logic                   wr_en,
    input  logic [VID_W-1:0]       wr_start,
    input  logic [VID_W-1:0]       wr_end,
    input  logic                   wr_closed,
    input  logic                   in_set,
    input  logic                   at_idx,
    input  logic [VID_W-1:0]       bcast_start,
    input  logic [VID_W-1:0]       bcast_end,
    input  logic                   seed_in,
    output logic                   seed_out,
    input  logic                   front_in,
    output logic                   front_out,
    input  logic [VID_W-1:0]       bus_start_in,
    output logic [VID_W-1:0]       bus_start_out,
    input  logic [VID_W-1:0]       bus_end_in,
    output logic [VID_W-1:0]       bus_end_out,
    output logic                   closed,
    output logic [ECC_LABEL_W-1:0] label
);

    logic [VID_W-1:0]       start_reg;
    logic [VID_W-1:0]       end_reg;
    logic                   closed_reg;
    logic [ECC_LABEL_W-1:0] label_reg;
    logic                   visited_reg;
    logic                   front_reg;
    logic                   seed_cand;
    logic                   seed_pick;
    logic                   front_pick;
    logic                   match;

    // first-unvisited and first-frontier picks ripple along the row
    assign seed_cand  = in_set && !visited_reg;
    assign seed_pick  = seed_cand && !seed_in;
    assign seed_out   = seed_in || seed_cand;
    assign front_pick = front_reg && !front_in;
    assign front_out  = front_in || front_reg;

    // endpoints of the picked frontier edge travel down the row
    assign bus_start_out = bus_start_in | (front_pick ? start_reg : '0);
    assign bus_end_out   = bus_end_in | (front_pick ? end_reg : '0);

    // shared endpoint with the broadcast edge
    assign match = in_set && !visited_reg && !closed_reg &&
                   (start_reg == bcast_start || start_reg == bcast_end ||
                    end_reg == bcast_start || end_reg == bcast_end);

    assign closed = closed_reg;
    assign label  = label_reg;

    // edge payload and label
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_reg  <= wr_start;
            end_reg    <= wr_end;
            closed_reg <= wr_closed;
        end
        if ((cmd.closed_en && at_idx && closed_reg) || (cmd.seed_en && seed_pick) ||
            (cmd.grow_en && match)) begin
            label_reg <= cmd.label;
        end
    end

    // visited and frontier marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= 1'b0;
            front_reg   <= 1'b0;
        end else if (cmd.clear_en || wr_en) begin
            visited_reg <= 1'b0;
            front_reg   <= 1'b0;
        end else if (cmd.closed_en) begin
            if (at_idx && closed_reg) begin
                visited_reg <= 1'b1;
            end
        end else if (cmd.seed_en) begin
            if (seed_pick) begin
                visited_reg <= 1'b1;
                front_reg   <= 1'b1;
            end
        end else if (cmd.grow_en) begin
            if (match) begin
                visited_reg <= 1'b1;
                front_reg   <= 1'b1;
            end else if (front_pick) begin
                front_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: src/edge_connected_components.sv
// Edge connected components labeler. Edges load one word per cycle into a row of
// MAX_EDGES cells; extra edges are dropped and flagged. The word marked last starts
// labeling: the stored edges are stepped through to number closed edges, then each
// open component is seeded, grown one frontier edge per grow step, the grow step
// broadcasting that edge's endpoints to all cells for comparison, and closed, until
// a last seed step finds no unvisited edge. Results then leave one word per cycle
// in load order when the output is not stalled; the input is held off until the last
// result is in the output register.
// top level; depends on ecc_pkg and ecc_cell
module edge_connected_components
    import ecc_pkg::*;
#(
    parameter int MAX_EDGES      = ECC_MAX_EDGES,
    parameter int VERTEX_ID_BITS = ECC_VERTEX_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ecc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ecc_out_t m_data
);

    localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    ecc_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       loaded_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ovf_reg;
    logic                   m_valid_reg;
    ecc_out_t               m_data_reg;

    ecc_cmd_t               cmd;
    logic                   accept;
    logic                   room;
    logic                   idx_last;
    logic                   emit_load;
    logic                   any_seed;
    logic                   any_front;
    logic [VERTEX_ID_BITS-1:0] wr_start;
    logic [VERTEX_ID_BITS-1:0] wr_end;

    logic [MAX_EDGES:0]     seed_chain;
    logic [MAX_EDGES:0]     front_chain;
    logic [VERTEX_ID_BITS-1:0] bus_start [MAX_EDGES+1];
    logic [VERTEX_ID_BITS-1:0] bus_end   [MAX_EDGES+1];
    logic [ECC_LABEL_W-1:0] cell_label [MAX_EDGES];
    logic [MAX_EDGES-1:0]   closed_vec;

    assign accept    = s_valid && s_ready;
    assign room      = loaded_reg < CNT_W'(MAX_EDGES);
    assign idx_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == loaded_reg;
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign any_seed  = seed_chain[MAX_EDGES];
    assign any_front = front_chain[MAX_EDGES];
    assign wr_start  = VERTEX_ID_BITS'(s_data.start_vertex);
    assign wr_end    = VERTEX_ID_BITS'(s_data.end_vertex);

    assign seed_chain[0]  = 1'b0;
    assign front_chain[0] = 1'b0;
    assign bus_start[0]   = '0;
    assign bus_end[0]     = '0;

    // row of edge cells
    for (genvar k = 0; k < MAX_EDGES; k++) begin : g_cell
        ecc_cell #(
            .VID_W(VERTEX_ID_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .wr_en        (accept && room && (loaded_reg[IDX_W-1:0] == IDX_W'(k))),
            .wr_start     (wr_start),
            .wr_end       (wr_end),
            .wr_closed    (s_data.is_closed),
            .in_set       (CNT_W'(k) < loaded_reg),
            .at_idx       (idx_reg == IDX_W'(k)),
            .bcast_start  (bus_start[MAX_EDGES]),
            .bcast_end    (bus_end[MAX_EDGES]),
            .seed_in      (seed_chain[k]),
            .seed_out     (seed_chain[k+1]),
            .front_in     (front_chain[k]),
            .front_out    (front_chain[k+1]),
            .bus_start_in (bus_start[k]),
            .bus_start_out(bus_start[k+1]),
            .bus_end_in   (bus_end[k]),
            .bus_end_out  (bus_end[k+1]),
            .closed       (closed_vec[k]),
            .label        (cell_label[k])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && s_data.last_edge) begin
                    state_next = ST_CLOSED;
                end
            end
            ST_CLOSED: begin
                if (idx_last) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                state_next = any_seed ? ST_GROW : ST_EMIT;
            end
            ST_GROW: begin
                if (!any_front) begin
                    state_next = ST_SEED;
                end
            end
            ST_EMIT: begin
                if (emit_load && idx_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // cell commands and handshake outputs
    always_comb begin
        cmd.clear_en  = emit_load && idx_last;
        cmd.closed_en = (state_reg == ST_CLOSED);
        cmd.seed_en   = (state_reg == ST_SEED);
        cmd.grow_en   = (state_reg == ST_GROW) && any_front;
        cmd.label     = ECC_LABEL_W'(count_reg);
        s_ready       = (state_reg == ST_LOAD);
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            idx_reg     <= '0;
            loaded_reg  <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output register fills on a load, empties once taken
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            loaded_reg <= loaded_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        idx_reg   <= '0;
                        count_reg <= '0;
                    end
                end
                ST_CLOSED: begin
                    if (closed_vec[idx_reg]) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
                end
                ST_SEED: begin
                    idx_reg <= '0;
                end
                ST_GROW: begin
                    if (!any_front) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        if (idx_last) begin
                            idx_reg    <= '0;
                            loaded_reg <= '0;
                            ovf_reg    <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_data_reg.edge_number     <= ECC_NUM_W'(idx_reg);
            m_data_reg.component_label <= cell_label[idx_reg];
            m_data_reg.component_total <= ECC_TOTAL_W'(count_reg);
            m_data_reg.overflow_flag   <= ovf_reg;
            m_data_reg.final_result    <= idx_last;
        end
    end

endmodule

FILE: src/ecc_checker.sv
// ecc_checker: port-level checks for edge_connected_components, bound to the top level
// depends on ecc_pkg
module ecc_checker
    import ecc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ecc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ecc_out_t m_data
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // label stays below the component count
    a_label: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.component_label} < m_data.component_total))
        else $error("label out of range");

    // results of one set leave back to back
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.final_result |=> m_valid)
        else $error("gap inside result burst");

    // no input taken while a set is being emitted
    a_noload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.final_result |-> !(s_valid && s_ready))
        else $error("input accepted during result burst");

endmodule

bind edge_connected_components ecc_checker u_ecc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

FILE: tb/edge_connected_components_tb.sv
// testbench for edge_connected_components: loads random and directed edge sets,
// predicts the component labels of every set and checks each output word in order
// depends on ecc_pkg and the edge_connected_components rtl
module edge_connected_components_tb;
    import ecc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // label predictor and queue of expected output words
    class label_scoreboard;
        ecc_in_t  set_edges[$];
        bit       set_dropped;
        ecc_out_t pending_words[$];
        int       mismatches;

        function new();
            mismatches = 0;
            set_dropped = 0;
        endfunction

        function bit touches(ecc_in_t a, ecc_in_t b);
            return a.start_vertex == b.start_vertex || a.start_vertex == b.end_vertex ||
                   a.end_vertex == b.start_vertex || a.end_vertex == b.end_vertex;
        endfunction

        // note one accepted edge; a last edge produces the labeled set
        function void note_edge(ecc_in_t w);
            int labels[$];
            bit seen[$];
            int walk[$];
            int n, comp, cur;
            ecc_out_t r;
            if (set_edges.size() < ECC_MAX_EDGES) set_edges.push_back(w);
            else set_dropped = 1;
            if (!w.last_edge) return;
            n = set_edges.size();
            labels = {};
            seen = {};
            for (int i = 0; i < n; i++) begin
                labels.push_back(0);
                seen.push_back(0);
            end
            comp = 0;
            // closed edges first
            for (int i = 0; i < n; i++) begin
                if (set_edges[i].is_closed) begin
                    labels[i] = comp;
                    seen[i] = 1;
                    comp++;
                end
            end
            // flood open components by lowest index
            for (int i = 0; i < n; i++) begin
                if (seen[i]) continue;
                seen[i] = 1;
                walk = {i};
                while (walk.size() > 0) begin
                    cur = walk.pop_front();
                    labels[cur] = comp;
                    for (int j = 0; j < n; j++) begin
                        if (!seen[j] && touches(set_edges[cur], set_edges[j])) begin
                            seen[j] = 1;
                            walk.push_back(j);
                        end
                    end
                end
                comp++;
            end
            for (int i = 0; i < n; i++) begin
                r.edge_number     = i[ECC_NUM_W-1:0];
                r.component_label = labels[i][ECC_LABEL_W-1:0];
                r.component_total = comp[ECC_TOTAL_W-1:0];
                r.overflow_flag   = set_dropped;
                r.final_result    = (i == n - 1);
                pending_words.push_back(r);
            end
            set_edges = {};
            set_dropped = 0;
        endfunction

        // compare one output word with the oldest expectation
        function void check_word(ecc_out_t got);
            ecc_out_t e;
            if (pending_words.size() == 0) begin
                $error("unexpected output word %p", got);
                mismatches++;
                return;
            end
            e = pending_words.pop_front();
            if (got.edge_number != e.edge_number) begin
                $error("edge_number expected %0d actual %0d", e.edge_number, got.edge_number);
                mismatches++;
            end
            if (got.component_label != e.component_label) begin
                $error("component_label expected %0d actual %0d",
                       e.component_label, got.component_label);
                mismatches++;
            end
            if (got.component_total != e.component_total) begin
                $error("component_total expected %0d actual %0d",
                       e.component_total, got.component_total);
                mismatches++;
            end
            if (got.overflow_flag != e.overflow_flag) begin
                $error("overflow_flag expected %0d actual %0d",
                       e.overflow_flag, got.overflow_flag);
                mismatches++;
            end
            if (got.final_result != e.final_result) begin
                $error("final_result expected %0d actual %0d",
                       e.final_result, got.final_result);
                mismatches++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ecc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ecc_out_t m_data;

    label_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;

    edge_connected_components i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // output side: random stall, check every accepted word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drive one edge word and wait for its acceptance
    task automatic send_edge(input logic [15:0] sv, input logic [15:0] ev,
                             input logic cl, input logic lst);
        ecc_in_t w;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        w.start_vertex = sv;
        w.end_vertex   = ev;
        w.is_closed    = cl;
        w.last_edge    = lst;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_edge(w);
    endtask

    // random set: small vertex pool for shared endpoints, sometimes full range
    task automatic send_random_set(input int n);
        logic [15:0] pool;
        pool = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(15, 2));
        for (int i = 0; i < n; i++) begin
            send_edge(16'($urandom_range(pool)), 16'($urandom_range(pool)),
                      ($urandom_range(4) == 0), i == n - 1);
        end
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single open edge, single closed edge, extremes, chain
        send_edge(16'h0000, 16'hffff, 1'b0, 1'b1);
        send_edge(16'hffff, 16'h0000, 1'b1, 1'b1);
        send_edge(16'h0001, 16'h0002, 1'b0, 1'b0);
        send_edge(16'h0005, 16'h0006, 1'b1, 1'b0);
        send_edge(16'h0002, 16'h0003, 1'b0, 1'b0);
        send_edge(16'h0007, 16'h0008, 1'b0, 1'b0);
        send_edge(16'h0003, 16'h0001, 1'b0, 1'b1);
        // directed overflow: more edges than the row holds, with the last edge among those dropped
        for (int i = 0; i < 34; i++) send_edge(16'(i), 16'(i + 1), i[0], i == 33);

        // random sets over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 34 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 34 : 0;
            for (int k = 0; k < 70; ) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(36, 30) : $urandom_range(8, 1);
                send_random_set(n);
                k += n;
            end
        end
        s_valid <= 1'b0;

        while (board.pending_words.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/ecc_pkg.sv
src/ecc_cell.sv
src/edge_connected_components.sv
src/ecc_checker.sv
tb/edge_connected_components_tb.sv
